// ===== sv/vsrc_pkg.sv =====
// Shared types and constants for the video-synced root counter.
// Holds the beat structs, opcode and register codes, and mode word bit positions.
// No dependencies; every other file of the block uses it.
package vsrc_pkg;

  localparam int COUNT_W = 16;
  localparam int ACC_W   = 32;
  localparam int ADV_W   = 34;

  localparam logic [COUNT_W-1:0] WRAP_VALUE = 16'hFFFF;

  // Reciprocals for division by a constant. floor(x/3) for x < 2^32 is
  // (x * RECIP_BY3) >> 33; floor(x/3413) for x < 2^32 is (x * RECIP_BY3413) >> 43.
  localparam logic [31:0] RECIP_BY3        = 32'hAAAA_AAAB;
  localparam int          RECIP_BY3_SHIFT  = 33;
  localparam logic [31:0] RECIP_BY3413     = 32'd2577232061;
  localparam int          RECIP_BY3413_SHIFT = 43;

  // Mode word bit positions.
  localparam int MODE_SYNC      = 0;
  localparam int MODE_SMODE_LO  = 1;
  localparam int MODE_RESET_TGT = 3;
  localparam int MODE_IRQ_TGT   = 4;
  localparam int MODE_IRQ_WRAP  = 5;
  localparam int MODE_REPEAT    = 6;
  localparam int MODE_TOGGLE    = 7;
  localparam int MODE_SRC_LO    = 8;
  localparam int MODE_IRQ_LINE  = 10;
  localparam int MODE_REACHED   = 11;
  localparam int MODE_WRAPPED   = 12;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BLANK   = 2'd1,
    OP_MODE_WR = 2'd2,
    OP_MODE_RD = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_DOT    = 2'd0,
    KIND_HBLANK = 2'd1,
    KIND_SYS8   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REG_TIMER_KIND   = 2'd0,
    REG_TARGET_VALUE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SYNC_PAUSE       = 2'd0,
    SYNC_RESET       = 2'd1,
    SYNC_RESET_PAUSE = 2'd2,
    SYNC_WAIT_EDGE   = 2'd3
  } sync_mode_t;

  typedef enum logic [1:0] {
    DIV_X1P5   = 2'd0,
    DIV_BY6    = 2'd1,
    DIV_BY12   = 2'd2,
    DIV_BY3413 = 2'd3
  } div_sel_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  typedef struct packed {
    opcode_t             opcode;
    logic [COUNT_W-1:0]  cycles;
    logic                hblank;
    logic                vblank;
    logic [COUNT_W-1:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  count_value;
    logic [COUNT_W-1:0]  mode_readback;
    logic                irq_pulse;
  } result_t;

  typedef struct packed {
    kind_t               timer_kind;
    logic [COUNT_W-1:0]  target_value;
  } cfg_t;

endpackage

// ===== sv/video_synced_root_counter_top.sv =====
// Top level of the video-synced root counter: handshake stages and configuration registers.
// Depends on vsrc_pkg and vsrc_core.
//
// Usage. Three channels, all valid/ready:
//   item   - one beat per operation: tick (cycles elapsed), blank level update,
//            mode word write or mode word read.
//   result - exactly one beat per item: counter value after the item, the mode
//            word as read (zero unless the item was a mode read), and an
//            interrupt pulse bit.
//   cfg    - register writes: index 0 selects the counter kind, index 1 the
//            target. Always ready; write only while no item is in flight.
// An accepted item beat passes through the item register to the result register.
// Throughput: one item per cycle while the result receiver does not stall. The
// whole update (accumulate, divide through one 32x32 reciprocal multiplier,
// compare, interrupt) sits between the item register and the result register,
// so the counter state is current for the very next item.
// Reset (synchronous, active high) clears the counter, mode word, accumulator,
// latched blank levels, both configuration registers and both stages.
// When the result receiver stalls, one result waits in the output register and
// one more item is held in the item register; item_ready then drops.
module video_synced_root_counter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  vsrc_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output vsrc_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vsrc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vsrc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  vsrc_pkg::cfg_t    cfg;
  vsrc_pkg::item_t   item_q;
  logic              item_held;
  logic              step_en;
  vsrc_pkg::result_t core_result;
  vsrc_pkg::kind_t   kind_wr;

  // An item is processed when it sits in the item register and the result
  // register is empty or being emptied in this same cycle.
  assign step_en    = item_held && (!result_valid || result_ready);
  assign item_ready = !item_held || step_en;
  assign cfg_ready  = 1'b1;

  // Kind code 3 has no meaning of its own and runs as the system clock kind.
  assign kind_wr = (cfg_data[1:0] == vsrc_pkg::KIND_DOT ||
                    cfg_data[1:0] == vsrc_pkg::KIND_HBLANK) ?
                   vsrc_pkg::kind_t'(cfg_data[1:0]) : vsrc_pkg::KIND_SYS8;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timer_kind   <= vsrc_pkg::KIND_DOT;
      cfg.target_value <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (vsrc_pkg::cfg_reg_t'(cfg_index))
        vsrc_pkg::REG_TIMER_KIND:   cfg.timer_kind   <= kind_wr;
        vsrc_pkg::REG_TARGET_VALUE: cfg.target_value <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Item register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_held <= 1'b0;
    end else if (item_ready) begin
      item_held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      item_q <= item;
    end
  end

  vsrc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item_q),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step_en) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      result <= core_result;
    end
  end

endmodule

// ===== sv/vsrc_div.sv =====
// Accumulator divider: turns the cycle accumulator into a counter advance and a remainder.
// Divides by 6, 12 or 3413 through one reciprocal multiplier, or scales by 1.5.
// Depends on vsrc_pkg.
module vsrc_div (
  input  logic [vsrc_pkg::ACC_W-1:0] acc,
  input  vsrc_pkg::div_sel_t         sel,
  output logic [vsrc_pkg::ADV_W-1:0] advance,
  output logic [vsrc_pkg::ACC_W-1:0] remainder
);

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] product;
  logic [29:0] q_by6;
  logic [28:0] q_by12;
  logic [20:0] q_by3413;
  logic [31:0] q3413_ext;
  logic [31:0] rem_by6;
  logic [31:0] rem_by12;
  logic [31:0] rem_by3413;

  // Division by 6 is a halving followed by a division by 3.
  assign mul_a   = (sel == vsrc_pkg::DIV_BY3413) ? acc : {1'b0, acc[31:1]};
  assign mul_b   = (sel == vsrc_pkg::DIV_BY3413) ? vsrc_pkg::RECIP_BY3413 : vsrc_pkg::RECIP_BY3;
  assign product = 64'(mul_a) * 64'(mul_b);

  assign q_by6    = product[vsrc_pkg::RECIP_BY3_SHIFT +: 30];
  assign q_by12   = q_by6[29:1];
  assign q_by3413 = product[vsrc_pkg::RECIP_BY3413_SHIFT +: 21];
  assign q3413_ext = 32'(q_by3413);

  assign rem_by6  = acc - ({q_by6, 2'b00} + {1'b0, q_by6, 1'b0});
  assign rem_by12 = acc - ({q_by12, 3'b000} + {1'b0, q_by12, 2'b00});
  // 3413 = 2048 + 1024 + 256 + 64 + 16 + 4 + 1
  assign rem_by3413 = acc - ((q3413_ext << 11) + (q3413_ext << 10) + (q3413_ext << 8) +
                             (q3413_ext << 6) + (q3413_ext << 4) + (q3413_ext << 2) +
                             q3413_ext);

  always_comb begin
    unique case (sel)
      vsrc_pkg::DIV_X1P5: begin
        advance   = vsrc_pkg::ADV_W'(acc) + vsrc_pkg::ADV_W'(acc[31:1]);
        remainder = '0;
      end
      vsrc_pkg::DIV_BY6: begin
        advance   = vsrc_pkg::ADV_W'(q_by6);
        remainder = rem_by6;
      end
      vsrc_pkg::DIV_BY12: begin
        advance   = vsrc_pkg::ADV_W'(q_by12);
        remainder = rem_by12;
      end
      vsrc_pkg::DIV_BY3413: begin
        advance   = vsrc_pkg::ADV_W'(q_by3413);
        remainder = rem_by3413;
      end
      default: begin
        advance   = '0;
        remainder = '0;
      end
    endcase
  end

endmodule

// ===== sv/vsrc_core.sv =====
// Counter state and the single-pass update for one item: sync gating, advance,
// target and wrap compares, flag and interrupt logic. Depends on vsrc_pkg and vsrc_div.
module vsrc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step_en,
  input  vsrc_pkg::item_t item,
  input  vsrc_pkg::cfg_t  cfg,
  output vsrc_pkg::result_t result
);

  logic [vsrc_pkg::COUNT_W-1:0] count;
  logic [vsrc_pkg::COUNT_W-1:0] count_next;
  logic [vsrc_pkg::COUNT_W-1:0] mode_word;
  logic [vsrc_pkg::COUNT_W-1:0] mode_word_next;
  logic [vsrc_pkg::ACC_W-1:0]   cycle_accum;
  logic [vsrc_pkg::ACC_W-1:0]   cycle_accum_next;
  logic                         one_shot_fired;
  logic                         one_shot_fired_next;
  logic                         hblank_now;
  logic                         hblank_now_next;
  logic                         hblank_prev;
  logic                         hblank_prev_next;
  logic                         vblank_now;
  logic                         vblank_now_next;
  logic                         vblank_prev;
  logic                         vblank_prev_next;

  logic [vsrc_pkg::ACC_W-1:0]   acc_sum;
  logic [vsrc_pkg::ADV_W-1:0]   div_advance;
  logic [vsrc_pkg::ACC_W-1:0]   div_rem;
  vsrc_pkg::div_sel_t           div_sel;
  vsrc_pkg::sync_mode_t         smode;
  logic [1:0]                   src;
  logic                         sync_on;
  logic                         paused;
  logic                         drop_acc;
  logic                         start_zero;
  logic                         drop_sync;
  logic [vsrc_pkg::ADV_W-1:0]   t_adv;
  logic [vsrc_pkg::ADV_W-1:0]   t_tgt;
  logic [vsrc_pkg::ADV_W-1:0]   t_final;
  logic                         reached;
  logic                         wrapped;
  logic                         fire;
  logic [vsrc_pkg::COUNT_W-1:0] tick_mode;
  logic                         tick_shot;
  logic                         tick_irq;
  logic [vsrc_pkg::COUNT_W-1:0] readback;
  logic                         irq;

  assign acc_sum = cycle_accum + vsrc_pkg::ACC_W'(item.cycles);
  assign sync_on = mode_word[vsrc_pkg::MODE_SYNC];
  assign smode   = vsrc_pkg::sync_mode_t'(mode_word[vsrc_pkg::MODE_SMODE_LO +: 2]);
  assign src     = mode_word[vsrc_pkg::MODE_SRC_LO +: 2];

  vsrc_div u_div (
    .acc       (acc_sum),
    .sel       (div_sel),
    .advance   (div_advance),
    .remainder (div_rem)
  );

  // Sync gating and choice of clock source per counter kind.
  always_comb begin
    paused     = 1'b0;
    drop_acc   = 1'b0;
    start_zero = 1'b0;
    drop_sync  = 1'b0;
    div_sel    = vsrc_pkg::DIV_X1P5;
    unique case (cfg.timer_kind)
      vsrc_pkg::KIND_DOT: begin
        div_sel = src[0] ? vsrc_pkg::DIV_BY6 : vsrc_pkg::DIV_X1P5;
        if (sync_on) begin
          unique case (smode)
            vsrc_pkg::SYNC_PAUSE: begin
              paused = hblank_now;
            end
            vsrc_pkg::SYNC_RESET: begin
              start_zero = hblank_now;
            end
            vsrc_pkg::SYNC_RESET_PAUSE: begin
              start_zero = hblank_now;
              paused     = !hblank_now;
            end
            vsrc_pkg::SYNC_WAIT_EDGE: begin
              drop_sync = !hblank_prev && hblank_now;
              paused    = !drop_sync;
            end
          endcase
        end
      end
      vsrc_pkg::KIND_HBLANK: begin
        div_sel = src[0] ? vsrc_pkg::DIV_BY3413 : vsrc_pkg::DIV_X1P5;
        if (sync_on) begin
          case (smode)
            vsrc_pkg::SYNC_RESET_PAUSE: begin
              start_zero = vblank_now;
            end
            vsrc_pkg::SYNC_WAIT_EDGE: begin
              drop_sync = !vblank_prev && vblank_now;
              paused    = !drop_sync;
            end
            default: begin
            end
          endcase
        end
      end
      vsrc_pkg::KIND_SYS8: begin
        div_sel = src[1] ? vsrc_pkg::DIV_BY12 : vsrc_pkg::DIV_X1P5;
        if (sync_on && (smode == vsrc_pkg::SYNC_PAUSE || smode == vsrc_pkg::SYNC_WAIT_EDGE)) begin
          paused   = 1'b1;
          drop_acc = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Advance, compare against target and wrap value, then interrupt handling.
  always_comb begin
    t_adv   = (start_zero ? '0 : vsrc_pkg::ADV_W'(count)) + div_advance;
    reached = t_adv >= vsrc_pkg::ADV_W'(cfg.target_value);
    t_tgt   = (reached && mode_word[vsrc_pkg::MODE_RESET_TGT]) ? '0 : t_adv;
    wrapped = t_tgt >= vsrc_pkg::ADV_W'(vsrc_pkg::WRAP_VALUE);
    t_final = (wrapped && !mode_word[vsrc_pkg::MODE_RESET_TGT]) ? '0 : t_tgt;
    fire    = (reached && mode_word[vsrc_pkg::MODE_IRQ_TGT]) ||
              (wrapped && mode_word[vsrc_pkg::MODE_IRQ_WRAP]);

    tick_mode = mode_word;
    if (drop_sync) begin
      tick_mode[vsrc_pkg::MODE_SYNC] = 1'b0;
    end
    tick_mode[vsrc_pkg::MODE_REACHED] = mode_word[vsrc_pkg::MODE_REACHED] | reached;
    tick_mode[vsrc_pkg::MODE_WRAPPED] = mode_word[vsrc_pkg::MODE_WRAPPED] | wrapped;
    tick_shot = one_shot_fired;
    tick_irq  = 1'b0;
    if (fire) begin
      if (mode_word[vsrc_pkg::MODE_TOGGLE]) begin
        tick_mode[vsrc_pkg::MODE_IRQ_LINE] = !mode_word[vsrc_pkg::MODE_IRQ_LINE];
      end else begin
        tick_mode[vsrc_pkg::MODE_IRQ_LINE] = 1'b0;
      end
      // A one-shot interrupt that already fired leaves the line bit as updated.
      if (mode_word[vsrc_pkg::MODE_REPEAT] || !one_shot_fired) begin
        tick_irq = 1'b1;
        tick_mode[vsrc_pkg::MODE_IRQ_LINE] = 1'b1;
        if (!mode_word[vsrc_pkg::MODE_REPEAT]) begin
          tick_shot = 1'b1;
        end
      end
    end
  end

  // Per-opcode next state.
  always_comb begin
    count_next          = count;
    mode_word_next      = mode_word;
    cycle_accum_next    = cycle_accum;
    one_shot_fired_next = one_shot_fired;
    hblank_now_next     = hblank_now;
    hblank_prev_next    = hblank_prev;
    vblank_now_next     = vblank_now;
    vblank_prev_next    = vblank_prev;
    readback            = '0;
    irq                 = 1'b0;
    if (step_en) begin
      unique case (item.opcode)
        vsrc_pkg::OP_TICK: begin
          if (paused) begin
            cycle_accum_next = drop_acc ? '0 : acc_sum;
          end else begin
            count_next          = t_final[vsrc_pkg::COUNT_W-1:0];
            mode_word_next      = tick_mode;
            cycle_accum_next    = div_rem;
            one_shot_fired_next = tick_shot;
            irq                 = tick_irq;
          end
        end
        vsrc_pkg::OP_BLANK: begin
          hblank_prev_next = hblank_now;
          vblank_prev_next = vblank_now;
          hblank_now_next  = item.hblank;
          vblank_now_next  = item.vblank;
        end
        vsrc_pkg::OP_MODE_WR: begin
          mode_word_next = item.write_data;
          mode_word_next[vsrc_pkg::MODE_IRQ_LINE] = 1'b1;
          one_shot_fired_next = 1'b0;
          count_next = '0;
        end
        vsrc_pkg::OP_MODE_RD: begin
          readback = mode_word;
          mode_word_next[vsrc_pkg::MODE_REACHED] = 1'b0;
          mode_word_next[vsrc_pkg::MODE_WRAPPED] = 1'b0;
        end
      endcase
    end
  end

  assign result.count_value   = count_next;
  assign result.mode_readback = readback;
  assign result.irq_pulse     = irq;

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      mode_word      <= '0;
      cycle_accum    <= '0;
      one_shot_fired <= 1'b0;
      hblank_now     <= 1'b0;
      hblank_prev    <= 1'b0;
      vblank_now     <= 1'b0;
      vblank_prev    <= 1'b0;
    end else begin
      count          <= count_next;
      mode_word      <= mode_word_next;
      cycle_accum    <= cycle_accum_next;
      one_shot_fired <= one_shot_fired_next;
      hblank_now     <= hblank_now_next;
      hblank_prev    <= hblank_prev_next;
      vblank_now     <= vblank_now_next;
      vblank_prev    <= vblank_prev_next;
    end
  end

`ifndef SYNTHESIS
  a_mode_write_clears : assert property (@(posedge clk) disable iff (rst)
    (step_en && item.opcode == vsrc_pkg::OP_MODE_WR) |=>
      (count == '0 && mode_word[vsrc_pkg::MODE_IRQ_LINE] && !one_shot_fired))
    else $error("mode write did not restart the counter");

  a_read_clears_flags : assert property (@(posedge clk) disable iff (rst)
    (step_en && item.opcode == vsrc_pkg::OP_MODE_RD) |=>
      (!mode_word[vsrc_pkg::MODE_REACHED] && !mode_word[vsrc_pkg::MODE_WRAPPED]))
    else $error("mode read left a status flag set");

  a_irq_only_on_tick : assert property (@(posedge clk) disable iff (rst)
    (step_en && item.opcode != vsrc_pkg::OP_TICK) |-> !result.irq_pulse)
    else $error("interrupt raised by a non-tick beat");

  a_one_shot_marks : assert property (@(posedge clk) disable iff (rst)
    (step_en && result.irq_pulse && !mode_word[vsrc_pkg::MODE_REPEAT]) |=> one_shot_fired)
    else $error("one-shot interrupt not recorded");
`endif

endmodule
